[design/scpt_pkg.sv]
// ----------------------------------------------------------------------------
// scpt_pkg
// shared sizes for the sphere / convex polygon test: vertex store geometry,
// fixed-point field widths and the digit-serial multiplier layout
// ----------------------------------------------------------------------------
package scpt_pkg;

  // vertex store
  localparam int MAX_VERTICES = 32;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  // field widths
  localparam int COORD_W = 24;
  localparam int NORM_W  = 16;
  localparam int RSQ_W   = 48;
  localparam int VERT_W  = 3 * COORD_W;

  // shared multiplier: unsigned MUL_W x MUL_W, one DIGIT_W digit of b a cycle
  localparam int MUL_W     = 88;
  localparam int DIGIT_W   = 16;
  localparam int MUL_STEPS = (MUL_W + DIGIT_W - 1) / DIGIT_W;
  localparam int MUL_BW    = MUL_STEPS * DIGIT_W;
  localparam int PROD_W    = MUL_W + MUL_BW;
  localparam int STEP_W    = $clog2(MUL_STEPS);

endpackage

[design/sphere_convex_polygon_test_unit.sv]
// ----------------------------------------------------------------------------
// sphere_convex_polygon_test_unit
// sphere against convex polygon contact test in fixed point
// ----------------------------------------------------------------------------
// Vertices are loaded one beat each into a 32-entry vertex ram. The sphere
// centre, squared radius and polygon normal are captured from the first beat
// of a polygon. The beat flagged last_vertex starts the test and the input
// stays not ready until the single result (hit, status) is placed in the
// output register. The test walks the edges through one ram port and one
// shared digit-serial multiplier: pass one covers every edge, with more
// products for an edge the centre lies outside of, and pass two covers the
// flagged edges. Sending more than 32 vertices drops the extra ones and
// gives a miss with status set, without running the test.
// ----------------------------------------------------------------------------
module sphere_convex_polygon_test_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [23:0] vertex_x_i,
  input  logic signed [23:0] vertex_y_i,
  input  logic signed [23:0] vertex_z_i,
  input  logic        last_vertex_i,
  input  logic signed [23:0] center_x_i,
  input  logic signed [23:0] center_y_i,
  input  logic signed [23:0] center_z_i,
  input  logic [47:0] radius_squared_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic        status_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_S, ST_RD_E, ST_GET_E, ST_PREP, ST_LN,
    ST_MSTART, ST_MWAIT, ST_P2CHK, ST_DONE
  } state_e;

  // products run through the shared multiplier
  typedef enum logic [2:0] {
    OP_DOT, OP_LEN, OP_DD, OP_RL, OP_SLS, OP_DST, OP_SLE, OP_DTE
  } op_e;

  localparam int VW = scpt_pkg::COORD_W + 1;  // vertex differences
  localparam int LW = 42;                     // edge normal
  localparam int DW = 72;                     // signed edge dot
  localparam int AW = 56;                     // slab and distance sums
  localparam int OW = scpt_pkg::MUL_W + 1;    // signed operand

  state_e st_q;
  op_e    op_q;
  logic                        pass2_q;
  logic [scpt_pkg::CNT_W-1:0]  cnt_q;
  logic [scpt_pkg::CNT_W-1:0]  idx_q;
  logic                        ovf_q;
  logic [1:0]                  k_q;
  logic [scpt_pkg::MAX_VERTICES-1:0] flags_q;
  logic                        spchk_q;
  logic                        neg_q;

  logic signed [scpt_pkg::COORD_W-1:0] cen_q [3];
  logic signed [scpt_pkg::NORM_W-1:0]  nrm_q [3];
  logic [scpt_pkg::RSQ_W-1:0]          rsq_q;
  logic signed [scpt_pkg::COORD_W-1:0] sv_q  [3];
  logic signed [scpt_pkg::COORD_W-1:0] ev_q  [3];
  logic signed [VW-1:0]                lv_q  [3];
  logic signed [VW-1:0]                cs_q  [3];
  logic signed [VW-1:0]                ce_q  [3];
  logic signed [LW-1:0]                ln_q  [3];
  logic signed [DW-1:0]                dot_q;
  logic [scpt_pkg::MUL_W-1:0]          len2_q;
  logic [scpt_pkg::PROD_W-1:0]         dd_q;
  logic signed [AW-1:0]                acc_q;

  logic                        res_hit_q;
  logic                        res_status_q;
  logic                        out_valid_q;
  logic                        hit_q;
  logic                        status_q;

  // vertex ram port
  logic                        ram_we;
  logic [scpt_pkg::VIDX_W-1:0] ram_addr;
  logic [scpt_pkg::VERT_W-1:0] ram_rdata;

  // multiplier
  logic signed [OW-1:0]        op_a, op_b;
  logic [scpt_pkg::MUL_W-1:0]  mag_a, mag_b;
  logic                        mul_start, mul_busy, mul_done;
  logic [scpt_pkg::PROD_W-1:0] mul_prod;

  // derived terms
  logic                        in_acc;
  logic                        last_edge;
  logic [1:0]                  ia, ib;
  logic signed [40:0]          lp1, lp2;
  logic signed [DW-1:0]        term_d, dot_new;
  logic signed [AW-1:0]        term_s, acc_new;
  logic [scpt_pkg::MUL_W-1:0]  len2_new;
  logic signed [AW-1:0]        rsq_ext;

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign last_edge  = (idx_q == cnt_q - 1'b1);

  // ram: writes only while loading, reads start and end vertex of an edge
  assign ram_we = in_acc && (cnt_q < scpt_pkg::CNT_W'(scpt_pkg::MAX_VERTICES));
  always_comb begin
    unique case (st_q)
      ST_RD_S: ram_addr = (idx_q == '0) ? scpt_pkg::VIDX_W'(cnt_q - 1'b1)
                                        : scpt_pkg::VIDX_W'(idx_q - 1'b1);
      ST_RD_E: ram_addr = idx_q[scpt_pkg::VIDX_W-1:0];
      default: ram_addr = cnt_q[scpt_pkg::VIDX_W-1:0];
    endcase
  end

  scpt_ram #(
    .WIDTH (scpt_pkg::VERT_W),
    .DEPTH (scpt_pkg::MAX_VERTICES)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({vertex_x_i, vertex_y_i, vertex_z_i}),
    .rdata_o (ram_rdata)
  );

  // edge normal component k = (lv x n)[k], one component a cycle
  always_comb begin
    unique case (k_q)
      2'd0:    begin ia = 2'd1; ib = 2'd2; end
      2'd1:    begin ia = 2'd2; ib = 2'd0; end
      default: begin ia = 2'd0; ib = 2'd1; end
    endcase
  end
  assign lp1 = lv_q[ia] * nrm_q[ib];
  assign lp2 = lv_q[ib] * nrm_q[ia];

  // operand select for the shared multiplier
  always_comb begin
    unique case (op_q)
      OP_DOT:  begin op_a = OW'(cs_q[k_q]);  op_b = OW'(ln_q[k_q]); end
      OP_LEN:  begin op_a = OW'(ln_q[k_q]);  op_b = OW'(ln_q[k_q]); end
      OP_DD:   begin op_a = OW'(dot_q);      op_b = OW'(dot_q);     end
      OP_RL:   begin op_a = OW'(rsq_q);      op_b = OW'(len2_q);    end
      OP_SLS:  begin op_a = OW'(cs_q[k_q]);  op_b = OW'(lv_q[k_q]); end
      OP_DST:  begin op_a = OW'(cs_q[k_q]);  op_b = OW'(cs_q[k_q]); end
      OP_SLE:  begin op_a = OW'(ce_q[k_q]);  op_b = OW'(lv_q[k_q]); end
      default: begin op_a = OW'(ce_q[k_q]);  op_b = OW'(ce_q[k_q]); end
    endcase
  end
  assign mag_a     = op_a[OW-1] ? scpt_pkg::MUL_W'(-op_a) : op_a[scpt_pkg::MUL_W-1:0];
  assign mag_b     = op_b[OW-1] ? scpt_pkg::MUL_W'(-op_b) : op_b[scpt_pkg::MUL_W-1:0];
  assign mul_start = (st_q == ST_MSTART);

  scpt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mag_a),
    .b_i     (mag_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // signed product back from magnitude and sign
  assign term_d   = neg_q ? -$signed(mul_prod[DW-1:0]) : $signed(mul_prod[DW-1:0]);
  assign term_s   = neg_q ? -$signed(mul_prod[AW-1:0]) : $signed(mul_prod[AW-1:0]);
  assign dot_new  = dot_q + term_d;
  assign acc_new  = acc_q + term_s;
  assign len2_new = len2_q + mul_prod[scpt_pkg::MUL_W-1:0];
  assign rsq_ext  = $signed(AW'(rsq_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      op_q         <= OP_DOT;
      pass2_q      <= 1'b0;
      cnt_q        <= '0;
      idx_q        <= '0;
      ovf_q        <= 1'b0;
      k_q          <= '0;
      flags_q      <= '0;
      spchk_q      <= 1'b0;
      neg_q        <= 1'b0;
      cen_q        <= '{default: '0};
      nrm_q        <= '{default: '0};
      rsq_q        <= '0;
      sv_q         <= '{default: '0};
      ev_q         <= '{default: '0};
      lv_q         <= '{default: '0};
      cs_q         <= '{default: '0};
      ce_q         <= '{default: '0};
      ln_q         <= '{default: '0};
      dot_q        <= '0;
      len2_q       <= '0;
      dd_q         <= '0;
      acc_q        <= '0;
      res_hit_q    <= 1'b0;
      res_status_q <= 1'b0;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      status_q     <= 1'b0;
    end else begin
      // a result beat taken while no new one is loaded empties the register
      if (out_valid_q && out_ready_i && (st_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            // first beat of a polygon carries the query
            if (cnt_q == '0) begin
              cen_q <= '{center_x_i, center_y_i, center_z_i};
              nrm_q <= '{normal_x_i, normal_y_i, normal_z_i};
              rsq_q <= radius_squared_i;
            end
            if (ram_we) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_vertex_i) begin
              if (ovf_q || !ram_we) begin
                res_hit_q    <= 1'b0;
                res_status_q <= 1'b1;
                st_q         <= ST_DONE;
              end else begin
                res_status_q <= 1'b0;
                idx_q        <= '0;
                pass2_q      <= 1'b0;
                flags_q      <= '0;
                st_q         <= ST_RD_S;
              end
            end
          end
        end

        ST_RD_S: st_q <= ST_RD_E;

        ST_RD_E: begin
          sv_q <= '{ram_rdata[71:48], ram_rdata[47:24], ram_rdata[23:0]};
          st_q <= ST_GET_E;
        end

        ST_GET_E: begin
          ev_q <= '{ram_rdata[71:48], ram_rdata[47:24], ram_rdata[23:0]};
          st_q <= ST_PREP;
        end

        ST_PREP: begin
          for (int i = 0; i < 3; i++) begin
            lv_q[i] <= VW'(ev_q[i]) - VW'(sv_q[i]);
            cs_q[i] <= VW'(cen_q[i]) - VW'(sv_q[i]);
            ce_q[i] <= VW'(cen_q[i]) - VW'(ev_q[i]);
          end
          k_q <= '0;
          if (pass2_q) begin
            acc_q <= '0;
            op_q  <= OP_SLS;
            st_q  <= ST_MSTART;
          end else begin
            dot_q  <= '0;
            len2_q <= '0;
            st_q   <= ST_LN;
          end
        end

        ST_LN: begin
          ln_q[k_q] <= LW'(lp1) - LW'(lp2);
          if (k_q == 2'd2) begin
            k_q  <= '0;
            op_q <= OP_DOT;
            st_q <= ST_MSTART;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end

        ST_MSTART: begin
          neg_q <= op_a[OW-1] ^ op_b[OW-1];
          st_q  <= ST_MWAIT;
        end

        ST_MWAIT: begin
          if (mul_done) begin
            unique case (op_q)
              OP_DOT: begin
                dot_q <= dot_new;
                op_q  <= OP_LEN;
                st_q  <= ST_MSTART;
              end
              OP_LEN: begin
                len2_q <= len2_new;
                if (k_q != 2'd2) begin
                  k_q  <= k_q + 1'b1;
                  op_q <= OP_DOT;
                  st_q <= ST_MSTART;
                end else if (dot_q[DW-1]) begin
                  // centre on the outer side of this edge
                  op_q <= OP_DD;
                  st_q <= ST_MSTART;
                end else if (!last_edge) begin
                  idx_q <= idx_q + 1'b1;
                  st_q  <= ST_RD_S;
                end else if (flags_q == '0) begin
                  res_hit_q <= 1'b1;
                  st_q      <= ST_DONE;
                end else begin
                  idx_q   <= '0;
                  pass2_q <= 1'b1;
                  spchk_q <= 1'b0;
                  st_q    <= ST_P2CHK;
                end
              end
              OP_DD: begin
                dd_q <= mul_prod;
                op_q <= OP_RL;
                st_q <= ST_MSTART;
              end
              OP_RL: begin
                if (dd_q > mul_prod) begin
                  // farther out than the radius: clean miss
                  res_hit_q <= 1'b0;
                  st_q      <= ST_DONE;
                end else begin
                  flags_q[idx_q[scpt_pkg::VIDX_W-1:0]] <= 1'b1;
                  if (!last_edge) begin
                    idx_q <= idx_q + 1'b1;
                    st_q  <= ST_RD_S;
                  end else begin
                    idx_q   <= '0;
                    pass2_q <= 1'b1;
                    spchk_q <= 1'b0;
                    st_q    <= ST_P2CHK;
                  end
                end
              end
              default: begin
                // pass two: three-term sums, decision on the last term
                if (k_q != 2'd2) begin
                  acc_q <= acc_new;
                  k_q   <= k_q + 1'b1;
                  st_q  <= ST_MSTART;
                end else begin
                  k_q   <= '0;
                  acc_q <= '0;
                  priority if (op_q == OP_SLS && !acc_new[AW-1]) begin
                    op_q <= OP_SLE;
                    st_q <= ST_MSTART;
                  end else if (op_q == OP_SLS && !spchk_q) begin
                    // before the start vertex, not yet tested
                    op_q <= OP_DST;
                    st_q <= ST_MSTART;
                  end else if (op_q == OP_SLE && !acc_new[AW-1] && acc_new != '0) begin
                    // past the end vertex
                    op_q <= OP_DTE;
                    st_q <= ST_MSTART;
                  end else if (op_q == OP_SLE
                               || ((op_q == OP_DST || op_q == OP_DTE)
                                   && acc_new < rsq_ext)) begin
                    // centre within the edge slab or inside the radius of a vertex
                    res_hit_q <= 1'b1;
                    st_q      <= ST_DONE;
                  end else begin
                    // edge finished; a tested end vertex is the next start vertex
                    spchk_q <= (op_q == OP_DTE);
                    if (last_edge) begin
                      res_hit_q <= 1'b0;
                      st_q      <= ST_DONE;
                    end else begin
                      idx_q <= idx_q + 1'b1;
                      st_q  <= ST_P2CHK;
                    end
                  end
                end
              end
            endcase
          end
        end

        ST_P2CHK: begin
          if (flags_q[idx_q[scpt_pkg::VIDX_W-1:0]]) begin
            st_q <= ST_RD_S;
          end else begin
            spchk_q <= 1'b0;
            if (last_edge) begin
              res_hit_q <= 1'b0;
              st_q      <= ST_DONE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end

        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            hit_q       <= res_hit_q;
            status_q    <= res_status_q;
            cnt_q       <= '0;
            ovf_q       <= 1'b0;
            st_q        <= ST_IDLE;
          end
        end

        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign status_o    = status_q;

  // an overflowed polygon never reports a hit
  a_status_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && status_o))
    else $error("hit reported together with overflow status");

  // loading never overlaps a running product
  a_load_idle_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mul_busy)
    else $error("input ready while multiplier busy");

  // vertex count stays within the store
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= scpt_pkg::CNT_W'(scpt_pkg::MAX_VERTICES))
    else $error("vertex count beyond store depth");

  // a product only completes while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> st_q == ST_MWAIT)
    else $error("multiplier result arrived outside wait state");

endmodule

[design/scpt_ram.sv]
// ----------------------------------------------------------------------------
// scpt_ram
// generic single-port ram, one access a cycle (a write also reads the old word), registered read data
// ----------------------------------------------------------------------------
module scpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[design/scpt_mul.sv]
// ----------------------------------------------------------------------------
// scpt_mul
// digit-serial unsigned multiplier, one 16-bit digit of b per cycle,
// product accumulated from the top and shifted right each step
// ----------------------------------------------------------------------------
module scpt_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [scpt_pkg::MUL_W-1:0]    a_i,
  input  logic [scpt_pkg::MUL_W-1:0]    b_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [scpt_pkg::PROD_W-1:0]   prod_o
);

  localparam int SUM_W = scpt_pkg::MUL_W + scpt_pkg::DIGIT_W;

  logic [scpt_pkg::MUL_W-1:0]  a_q;
  logic [scpt_pkg::MUL_BW-1:0] b_q;
  logic [scpt_pkg::PROD_W-1:0] acc_q;
  logic [scpt_pkg::STEP_W-1:0] step_q;
  logic                        busy_q;
  logic                        done_q;
  logic [SUM_W-1:0]            sum;
  logic                        last_step;

  assign sum = SUM_W'(acc_q[scpt_pkg::PROD_W-1:scpt_pkg::MUL_BW])
             + SUM_W'(a_q) * SUM_W'(b_q[scpt_pkg::DIGIT_W-1:0]);

  assign last_step = (step_q == scpt_pkg::STEP_W'(scpt_pkg::MUL_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && last_step;
      if (start_i) begin
        a_q    <= a_i;
        b_q    <= scpt_pkg::MUL_BW'(b_i);
        acc_q  <= '0;
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q  <= {sum, acc_q[scpt_pkg::MUL_BW-1:scpt_pkg::DIGIT_W]};
        b_q    <= b_q >> scpt_pkg::DIGIT_W;
        step_q <= step_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[tb/sphere_convex_polygon_test_unit_tb.sv]
// ----------------------------------------------------------------------------
// sphere_convex_polygon_test_unit_tb
// self-checking bench for the sphere / convex polygon contact test
// ----------------------------------------------------------------------------
// Polygons are sent one vertex beat at a time. A directed list comes first:
// one vertex, two vertices, extreme fields, inside and outside centres and
// a vertex overflow. Random polygons follow. Most are convex, some of them
// large, and lie in an axis plane, with the centre in that plane near the
// polygon. The rest are noise polygons and overflows. Each result is compared
// with a bit-exact software copy of the test, updated on every accepted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_convex_polygon_test_unit_tb;

  // one input beat, plus an optional typed-in expectation
  typedef struct {
    logic signed [scpt_pkg::COORD_W-1:0] vx, vy, vz;
    logic                                last;
    logic signed [scpt_pkg::COORD_W-1:0] cx, cy, cz;
    logic [scpt_pkg::RSQ_W-1:0]          rsq;
    logic signed [scpt_pkg::NORM_W-1:0]  nx, ny, nz;
    bit                                  typed;
    bit                                  exp_hit, exp_status;
  } vertex_beat_t;

  typedef struct {
    bit hit;
    bit status;
  } contact_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, hit, status;
  logic signed [scpt_pkg::COORD_W-1:0] vertex_x, vertex_y, vertex_z;
  logic signed [scpt_pkg::COORD_W-1:0] center_x, center_y, center_z;
  logic last_vertex;
  logic [scpt_pkg::RSQ_W-1:0] radius_squared;
  logic signed [scpt_pkg::NORM_W-1:0] normal_x, normal_y, normal_z;

  sphere_convex_polygon_test_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .vertex_x_i      (vertex_x),
    .vertex_y_i      (vertex_y),
    .vertex_z_i      (vertex_z),
    .last_vertex_i   (last_vertex),
    .center_x_i      (center_x),
    .center_y_i      (center_y),
    .center_z_i      (center_z),
    .radius_squared_i(radius_squared),
    .normal_x_i      (normal_x),
    .normal_y_i      (normal_y),
    .normal_z_i      (normal_z),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .hit_o           (hit),
    .status_o        (status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // -------------------------------------------------------------------------
  // predictor state: mirrors what the block holds for the open polygon
  // -------------------------------------------------------------------------
  longint poly_x[scpt_pkg::MAX_VERTICES];
  longint poly_y[scpt_pkg::MAX_VERTICES];
  longint poly_z[scpt_pkg::MAX_VERTICES];
  int     poly_count;
  bit     poly_overflow;
  longint q_center[3], q_normal[3], q_rsq;

  contact_t     contact_q[$];  // results still owed by the block
  vertex_beat_t beat_list[$];
  int           errors;
  int           beats_sent;
  bit           quiet;         // no idling on either side in the last stretch

  function automatic void get_vertex(int idx, output longint p[3]);
    p[0] = poly_x[idx];
    p[1] = poly_y[idx];
    p[2] = poly_z[idx];
  endfunction

  function automatic longint dist_sq(longint c[3], longint p[3]);
    return (c[0]-p[0])*(c[0]-p[0]) + (c[1]-p[1])*(c[1]-p[1]) + (c[2]-p[2])*(c[2]-p[2]);
  endfunction

  function automatic longint slab_dot(longint c[3], longint p[3], longint lv[3]);
    return (c[0]-p[0])*lv[0] + (c[1]-p[1])*lv[1] + (c[2]-p[2])*lv[2];
  endfunction

  // edge passes over the loaded polygon, every edge first and then the flagged edges, full-width arithmetic
  function automatic bit polygon_contact();
    int i, k, n;
    longint s[3], e[3], lv[3], ln[3];
    logic signed [191:0] dot, len2, fa, fb, dd, rl, diff;
    logic [scpt_pkg::MAX_VERTICES-1:0] flagged;
    bit start_done, end_done;
    n = poly_count;
    flagged = '0;
    for (i = 0; i < n; i++) begin
      get_vertex((i == 0) ? n - 1 : i - 1, s);
      get_vertex(i, e);
      for (k = 0; k < 3; k++) lv[k] = e[k] - s[k];
      ln[0] = lv[1] * q_normal[2] - lv[2] * q_normal[1];
      ln[1] = lv[2] * q_normal[0] - lv[0] * q_normal[2];
      ln[2] = lv[0] * q_normal[1] - lv[1] * q_normal[0];
      dot = '0;
      len2 = '0;
      for (k = 0; k < 3; k++) begin
        fa = 192'(q_center[k] - s[k]);
        fb = 192'(ln[k]);
        dot = dot + fa * fb;
        len2 = len2 + fb * fb;
      end
      if (dot < 0) begin
        // centre outside this edge: miss if beyond the radius
        dd = dot * dot;
        fa = 192'(q_rsq);
        rl = fa * len2;
        diff = dd - rl;
        if (diff > 0) return 1'b0;
        flagged[i] = 1'b1;
      end
    end
    if (flagged == '0) return 1'b1;

    // second pass: slab of each flagged edge, then its nearer end vertex
    start_done = 1'b0;
    for (i = 0; i < n; i++) begin
      end_done = 1'b0;
      if (flagged[i]) begin
        get_vertex((i == 0) ? n - 1 : i - 1, s);
        get_vertex(i, e);
        for (k = 0; k < 3; k++) lv[k] = e[k] - s[k];
        if (slab_dot(q_center, s, lv) < 0) begin
          if (!start_done && dist_sq(q_center, s) < q_rsq) return 1'b1;
        end else if (slab_dot(q_center, e, lv) > 0) begin
          if (dist_sq(q_center, e) < q_rsq) return 1'b1;
          end_done = 1'b1;
        end else begin
          return 1'b1;
        end
      end
      start_done = end_done;
    end
    return 1'b0;
  endfunction

  // update the predictor with one accepted beat; queue a result on the last one
  task automatic accept_beat(vertex_beat_t b);
    contact_t r;
    if (poly_count == 0 && !poly_overflow) begin
      q_center[0] = longint'(b.cx);
      q_center[1] = longint'(b.cy);
      q_center[2] = longint'(b.cz);
      q_rsq       = longint'(b.rsq);
      q_normal[0] = longint'(b.nx);
      q_normal[1] = longint'(b.ny);
      q_normal[2] = longint'(b.nz);
    end
    if (poly_count < scpt_pkg::MAX_VERTICES) begin
      poly_x[poly_count] = longint'(b.vx);
      poly_y[poly_count] = longint'(b.vy);
      poly_z[poly_count] = longint'(b.vz);
      poly_count++;
    end else begin
      poly_overflow = 1'b1;
    end
    if (b.last) begin
      r.status = poly_overflow;
      r.hit    = poly_overflow ? 1'b0 : polygon_contact();
      if (b.typed) begin
        r.hit    = b.exp_hit;
        r.status = b.exp_status;
      end
      contact_q = {contact_q, r};
      poly_count    = 0;
      poly_overflow = 1'b0;
    end
  endtask

  // -------------------------------------------------------------------------
  // input side: random idle bursts, then hold the beat until accepted
  // -------------------------------------------------------------------------
  task automatic send_beat(vertex_beat_t b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    vertex_x       <= b.vx;
    vertex_y       <= b.vy;
    vertex_z       <= b.vz;
    last_vertex    <= b.last;
    center_x       <= b.cx;
    center_y       <= b.cy;
    center_z       <= b.cz;
    radius_squared <= b.rsq;
    normal_x       <= b.nx;
    normal_y       <= b.ny;
    normal_z       <= b.nz;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    accept_beat(b);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic vertex_beat_t noise_beat();
    vertex_beat_t b;
    b.vx = scpt_pkg::COORD_W'($urandom);
    b.vy = scpt_pkg::COORD_W'($urandom);
    b.vz = scpt_pkg::COORD_W'($urandom);
    b.cx = scpt_pkg::COORD_W'($urandom);
    b.cy = scpt_pkg::COORD_W'($urandom);
    b.cz = scpt_pkg::COORD_W'($urandom);
    b.rsq = scpt_pkg::RSQ_W'({$urandom, $urandom});
    b.nx = scpt_pkg::NORM_W'($urandom);
    b.ny = scpt_pkg::NORM_W'($urandom);
    b.nz = scpt_pkg::NORM_W'($urandom);
    b.last = 1'b0;
    b.typed = 1'b0;
    b.exp_hit = 1'b0;
    b.exp_status = 1'b0;
    return b;
  endfunction

  function automatic vertex_beat_t mk_beat(longint x, longint y, longint z, bit last,
                                           longint cx, longint cy, longint cz,
                                           longint rsq, longint nx, longint ny, longint nz);
    vertex_beat_t b;
    b = noise_beat();
    b.vx = scpt_pkg::COORD_W'(x);
    b.vy = scpt_pkg::COORD_W'(y);
    b.vz = scpt_pkg::COORD_W'(z);
    b.last = last;
    b.cx = scpt_pkg::COORD_W'(cx);
    b.cy = scpt_pkg::COORD_W'(cy);
    b.cz = scpt_pkg::COORD_W'(cz);
    b.rsq = scpt_pkg::RSQ_W'(rsq);
    b.nx = scpt_pkg::NORM_W'(nx);
    b.ny = scpt_pkg::NORM_W'(ny);
    b.nz = scpt_pkg::NORM_W'(nz);
    return b;
  endfunction

  // convex polygon in an axis plane, centre in that plane near it
  task automatic send_convex(int n);
    vertex_beat_t b;
    real rad, step, ang, cu, cw;
    longint bu, bw, plane, sgn, u, w, cru, crw, r;
    int axis, i;
    axis  = $urandom_range(0, 2);
    sgn   = $urandom_range(0, 1) ? 64'sd1 : -64'sd1;
    rad   = real'($urandom_range(4, 1 << $urandom_range(4, 20)));
    bu    = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    bw    = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    plane = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    step  = ($urandom_range(0, 1) ? 1.0 : -1.0) * 6.283185307 / n;
    ang   = real'($urandom_range(0, 999)) / 159.0;
    cu    = rad * (real'($urandom_range(0, 3000)) / 1000.0 - 1.5);
    cw    = rad * (real'($urandom_range(0, 3000)) / 1000.0 - 1.5);
    cru   = bu + longint'($rtoi(cu));
    crw   = bw + longint'($rtoi(cw));
    r     = longint'($rtoi(rad * real'($urandom_range(0, 1500)) / 1000.0));
    for (i = 0; i < n; i++) begin
      u = bu + longint'($rtoi(rad * $cos(ang + step * i)));
      w = bw + longint'($rtoi(rad * $sin(ang + step * i)));
      case (axis)
        0: b = mk_beat(plane, u, w, 0, plane, cru, crw, r * r, sgn * 16384, 0, 0);
        1: b = mk_beat(w, plane, u, 0, crw, plane, cru, r * r, 0, sgn * 16384, 0);
        default: b = mk_beat(u, w, plane, 0, cru, crw, plane, r * r, 0, 0, sgn * 16384);
      endcase
      // only the first beat of a polygon carries the query
      if (i != 0) begin
        b.cx = scpt_pkg::COORD_W'($urandom);
        b.cy = scpt_pkg::COORD_W'($urandom);
        b.cz = scpt_pkg::COORD_W'($urandom);
        b.rsq = scpt_pkg::RSQ_W'({$urandom, $urandom});
        b.nx = scpt_pkg::NORM_W'($urandom);
        b.ny = scpt_pkg::NORM_W'($urandom);
        b.nz = scpt_pkg::NORM_W'($urandom);
      end
      b.last = (i == n - 1);
      send_beat(b);
    end
  endtask

  task automatic send_noise(int n);
    vertex_beat_t b;
    int i;
    for (i = 0; i < n; i++) begin
      b = noise_beat();
      b.last = (i == n - 1);
      send_beat(b);
    end
  endtask

  // -------------------------------------------------------------------------
  // output side: random stall bursts, compare each beat with the oldest result
  // -------------------------------------------------------------------------
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    contact_t e;
    if (rst_n && out_valid && out_ready) begin
      if (contact_q.size() == 0) begin
        $error("result beat with nothing expected: hit %0d status %0d", hit, status);
        errors++;
      end else begin
        e = contact_q.pop_front();
        if (hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, hit);
          errors++;
        end
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          errors++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    vertex_beat_t b;
    int i, kind;
    errors = 0;
    beats_sent = 0;
    quiet = 1'b0;
    poly_count = 0;
    poly_overflow = 1'b0;
    in_valid = 1'b0;
    b = noise_beat();
    {vertex_x, vertex_y, vertex_z, center_x, center_y, center_z} = '0;
    {last_vertex, radius_squared, normal_x, normal_y, normal_z} = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single vertex: zero edge, always a hit
    b = mk_beat(0, 0, 0, 1, 1000, -1000, 0, 0, 0, 0, 16384);
    b.typed = 1; b.exp_hit = 1; b.exp_status = 0;
    beat_list = {beat_list, b};
    // two vertices: degenerate polygon
    beat_list = {beat_list, mk_beat(0, 0, 0, 0, 256, 256, 0, 65536, 0, 0, 16384)};
    beat_list = {beat_list, mk_beat(512, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0)};
    // triangle, centre inside, zero radius, both windings
    beat_list = {beat_list, mk_beat(-2560, -2560, 0, 0, 0, 0, 0, 0, 0, 0, 16384)};
    beat_list = {beat_list, mk_beat(2560, -2560, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    beat_list = {beat_list, mk_beat(0, 2560, 0, 1, 0, 0, 0, 0, 0, 0, 0)};
    beat_list = {beat_list, mk_beat(-2560, -2560, 0, 0, 0, 0, 0, 0, 0, 0, -16384)};
    beat_list = {beat_list, mk_beat(0, 2560, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    beat_list = {beat_list, mk_beat(2560, -2560, 0, 1, 0, 0, 0, 0, 0, 0, 0)};
    // square, centre far off near a corner with a small and a large radius
    for (i = 0; i < 2; i++) begin
      beat_list = {beat_list, mk_beat(0, 0, 0, 0, -300, -300, 0,
                                      i ? 64'h100_0000_0000 : 1, 0, 0, 16384)};
      beat_list = {beat_list, mk_beat(2560, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      beat_list = {beat_list, mk_beat(2560, 2560, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      beat_list = {beat_list, mk_beat(0, 2560, 0, 1, 0, 0, 0, 0, 0, 0, 0)};
    end
    // extreme coordinates, normal and radius
    beat_list = {beat_list, mk_beat(-8388608, -8388608, -8388608, 0,
                                    8388607, 8388607, 8388607,
                                    64'hFFFF_FFFF_FFFF, -32768, 32767, -32768)};
    beat_list = {beat_list, mk_beat(8388607, -8388608, 8388607, 0, 0, 0, 0, 0, 0, 0, 0)};
    beat_list = {beat_list, mk_beat(8388607, 8388607, -8388608, 1, 0, 0, 0, 0, 0, 0, 0)};
    beat_list = {beat_list, mk_beat(8388607, 8388607, 8388607, 0,
                                    -8388608, -8388608, -8388608,
                                    0, 32767, -32768, 32767)};
    beat_list = {beat_list, mk_beat(-8388608, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    beat_list = {beat_list, mk_beat(0, -8388608, 8388607, 1, 0, 0, 0, 0, 0, 0, 0)};
    foreach (beat_list[j]) send_beat(beat_list[j]);

    // one vertex too many: miss with status set
    for (i = 0; i <= scpt_pkg::MAX_VERTICES; i++) begin
      b = noise_beat();
      b.last = (i == scpt_pkg::MAX_VERTICES);
      b.typed = b.last; b.exp_hit = 0; b.exp_status = 1;
      send_beat(b);
    end

    // random polygons
    while (beats_sent < 2000) begin
      if (beats_sent > 1700) quiet = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 78)      send_convex($urandom_range(3, 8));
      else if (kind < 83) send_convex($urandom_range(9, scpt_pkg::MAX_VERTICES));
      else if (kind < 95) send_noise($urandom_range(1, 5));
      else                send_noise($urandom_range(scpt_pkg::MAX_VERTICES + 1,
                                                    scpt_pkg::MAX_VERTICES + 4));
    end
    in_valid <= 1'b0;

    while (contact_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sphere_convex_polygon_test_unit");
    end else begin
      $display("FAIL sphere_convex_polygon_test_unit");
    end
    $finish;
  end

  // watchdog: generous bound on the whole run
  initial begin
    #50ms;
    $display("FAIL sphere_convex_polygon_test_unit");
    $finish;
  end

endmodule
